// ----- rtl/core/ipid_pkg.sv -----
// Shared types, constants and helpers for the incremental PID step block.
package ipid_pkg;

	localparam int DIVN_W = 48;
	localparam int DIVD_W = 32;
	localparam int ACC_W  = 51;
	localparam int WIDE_W = 52;

	localparam logic OP_COMPUTE = 1'b0;
	localparam logic OP_CLEAR   = 1'b1;

	localparam logic [2:0] REG_P_GAIN        = 3'd0;
	localparam logic [2:0] REG_I_GAIN        = 3'd1;
	localparam logic [2:0] REG_D_GAIN        = 3'd2;
	localparam logic [2:0] REG_DRIVE_FLOOR   = 3'd3;
	localparam logic [2:0] REG_DRIVE_CEILING = 3'd4;

	localparam logic signed [31:0] FLOOR_RST = 32'sd3932160;
	localparam logic signed [31:0] CEIL_RST  = 32'sd24903680;

	typedef struct packed {
		logic              operation;
		logic signed [31:0] target;
		logic signed [31:0] measured;
		logic [31:0]        interval;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] drive;
		logic               limited;
		logic               bad_interval;
	} out_item_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_COEF,
		ST_MA,
		ST_MB,
		ST_MC,
		ST_ACC,
		ST_OUT
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] x);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = WIDE_W'(32'sh7FFFFFFF);
		lo = WIDE_W'(32'sh80000000);
		if (x > hi) begin
			return 32'sh7FFFFFFF;
		end
		if (x < lo) begin
			return 32'sh80000000;
		end
		return x[31:0];
	endfunction

endpackage

// ----- rtl/core/ipid_div.sv -----
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
module ipid_div
	import ipid_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIVN_W-1:0] dividend,
	input  logic [DIVD_W-1:0] divisor,
	output div_stat_t         stat,
	output logic [DIVN_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIVN_W);

	logic [DIVD_W-1:0] rem_q;
	logic [DIVD_W-1:0] dsr_q;
	logic [DIVN_W-1:0] quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIVD_W:0]   rem_sh;
	logic [DIVD_W:0]   diff;

	assign rem_sh = {rem_q, quo_q[DIVN_W-1]};
	assign diff   = rem_sh - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(DIVN_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!diff[DIVD_W]) begin
				rem_q <= diff[DIVD_W-1:0];
				quo_q <= {quo_q[DIVN_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DIVD_W-1:0];
				quo_q <= {quo_q[DIVN_W-2:0], 1'b0};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

// ----- rtl/core/ipid_mul.sv -----
// Shared signed 33x33 multiplier with registered product.
module ipid_mul
	import ipid_pkg::*;
(
	input  logic               clk,
	input  logic signed [32:0] op_a,
	input  logic signed [32:0] op_b,
	output logic signed [65:0] prod
);

	logic signed [65:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

	assign prod = prod_q;

endmodule

// ----- rtl/core/incremental_pid_step_top.sv -----
// Top level of the velocity-form PID step: sequencer, registers and output stage.
// Compute item: the divider runs to completion, then the coefficient step, 3 multiplies and the accumulate.
// Zero-interval item: skips the divider and goes straight to the output state. Clear item: no result.
// One item at a time; the next is taken the cycle after the result enters the output register.
// Asynchronous reset: gains zero, limits 60.0 and 380.0, output and error history zero.
module incremental_pid_step_top
	import ipid_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_item,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_item,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	state_t state_q, state_d;

	logic signed [31:0] p_gain_q, i_gain_q, d_gain_q, floor_q, ceil_q;
	logic signed [31:0] prev_output_q, prev_error_q, older_error_q;
	logic signed [31:0] e_q, a_q, b_q, c_q;
	logic [31:0]        dt_q;
	logic               dneg_q, bad_q;
	logic signed [DIVN_W-1:0] cq_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic               out_valid_q;
	out_item_t          out_item_q;

	logic               accept, out_free, out_load, div_start;
	logic signed [32:0] op_a, op_b;
	logic signed [65:0] prod;
	logic signed [47:0] prod_sh;
	div_stat_t          div_stat;
	logic [DIVN_W-1:0]  quotient;
	logic [32:0]        d_neg;
	logic [31:0]        d_abs;
	logic signed [31:0] u_sat, u_val, drv;
	logic               lim;
	logic signed [WIDE_W-1:0] p_w, idt_w, cq_w;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign prod_sh  = prod[63:16];

	assign d_neg = -{d_gain_q[31], d_gain_q};
	assign d_abs = d_gain_q[31] ? d_neg[31:0] : d_gain_q;

	assign p_w   = WIDE_W'(p_gain_q);
	assign idt_w = WIDE_W'(prod_sh);
	assign cq_w  = WIDE_W'(cq_q);

	assign u_sat = sat32(WIDE_W'(acc_q));
	assign u_val = bad_q ? prev_output_q : u_sat;

	always_comb begin
		drv = u_val;
		lim = 1'b0;
		if (drv > ceil_q) begin
			drv = ceil_q;
			lim = 1'b1;
		end
		if (drv < floor_q) begin
			drv = floor_q;
			lim = 1'b1;
		end
	end

	ipid_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({d_abs, 16'b0}),
		.divisor  (in_item.interval),
		.stat     (div_stat),
		.quotient (quotient)
	);

	ipid_mul u_mul (
		.clk  (clk),
		.op_a (op_a),
		.op_b (op_b),
		.prod (prod)
	);

	always_comb begin
		state_d   = state_q;
		in_stall  = (state_q != ST_IDLE);
		div_start = 1'b0;
		out_load  = 1'b0;
		op_a      = {i_gain_q[31], i_gain_q};
		op_b      = {1'b0, dt_q};
		case (state_q)
			ST_IDLE: begin
				if (accept && in_item.operation == OP_COMPUTE) begin
					if (in_item.interval == '0) begin
						state_d = ST_OUT;
					end else begin
						div_start = 1'b1;
						state_d   = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					state_d = ST_COEF;
				end
			end
			ST_COEF: state_d = ST_MA;
			ST_MA: begin
				op_a    = 33'(a_q);
				op_b    = 33'(e_q);
				state_d = ST_MB;
			end
			ST_MB: begin
				op_a    = 33'(b_q);
				op_b    = 33'(prev_error_q);
				state_d = ST_MC;
			end
			ST_MC: begin
				op_a    = 33'(c_q);
				op_b    = 33'(older_error_q);
				state_d = ST_ACC;
			end
			ST_ACC: state_d = ST_OUT;
			ST_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_gain_q      <= '0;
			i_gain_q      <= '0;
			d_gain_q      <= '0;
			floor_q       <= FLOOR_RST;
			ceil_q        <= CEIL_RST;
			prev_output_q <= '0;
			prev_error_q  <= '0;
			older_error_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_P_GAIN:        p_gain_q <= cfg_data;
					REG_I_GAIN:        i_gain_q <= cfg_data;
					REG_D_GAIN:        d_gain_q <= cfg_data;
					REG_DRIVE_FLOOR:   floor_q  <= cfg_data;
					REG_DRIVE_CEILING: ceil_q   <= cfg_data;
					default: ;
				endcase
			end
			if (accept && in_item.operation == OP_CLEAR) begin
				prev_output_q <= '0;
				prev_error_q  <= '0;
				older_error_q <= '0;
			end
			if (out_load && !bad_q) begin
				prev_output_q <= u_sat;
				prev_error_q  <= e_q;
				older_error_q <= prev_error_q;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			e_q    <= sat32(WIDE_W'($signed(in_item.target)) -
				WIDE_W'($signed(in_item.measured)));
			dt_q   <= in_item.interval;
			bad_q  <= (in_item.interval == '0);
			dneg_q <= d_gain_q[31];
		end
		if (state_q == ST_DIV && div_stat.done) begin
			cq_q <= dneg_q ? -$signed(quotient) : $signed(quotient);
		end
		if (state_q == ST_COEF) begin
			a_q <= sat32(p_w + cq_w);
			b_q <= sat32(idt_w - p_w - (cq_w <<< 1));
			c_q <= sat32(cq_w);
		end
		case (state_q)
			ST_MB:   acc_q <= ACC_W'(prev_output_q) + ACC_W'(prod_sh);
			ST_MC:   acc_q <= acc_q + ACC_W'(prod_sh);
			ST_ACC:  acc_q <= acc_q + ACC_W'(prod_sh);
			default: ;
		endcase
		if (out_load) begin
			out_item_q.drive        <= drv;
			out_item_q.limited      <= lim;
			out_item_q.bad_interval <= bad_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_OUT)
		else $error("result appeared outside output state");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == ST_DIV)
		else $error("divider finished while sequencer not waiting");

	a_bad_holds_hist: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && bad_q && out_free) |=>
		($stable(prev_output_q) && $stable(prev_error_q) && $stable(older_error_q)))
		else $error("zero interval changed history");

endmodule

// ----- dv/pid_step_checker.sv -----
// Checker for the incremental PID step: tracks registers, predicts each drive item, compares.
`timescale 1ns / 1ps

module pid_step_checker
	import ipid_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  in_item_t    in_item,
	input  logic        out_valid,
	input  logic        out_stall,
	input  out_item_t   out_item,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          mismatches,
	output int          outstanding,
	output int          compared
);

	logic signed [31:0] kp, ki, kd, drive_lo, drive_hi;
	logic signed [31:0] last_u, err1, err2;
	out_item_t          drive_expect_q[$];

	function automatic logic signed [31:0] clip_word(input longint x);
		if (x > 64'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end
		if (x < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return 32'(x);
	endfunction

	// ceiling first, then floor: an inverted pair always yields the floor
	function automatic out_item_t clamp_drive(input logic signed [31:0] u, input logic bad);
		out_item_t          r;
		logic signed [31:0] v;
		v = u;
		r.limited = 1'b0;
		if (v > drive_hi) begin
			v = drive_hi;
			r.limited = 1'b1;
		end
		if (v < drive_lo) begin
			v = drive_lo;
			r.limited = 1'b1;
		end
		r.drive = v;
		r.bad_interval = bad;
		return r;
	endfunction

	function automatic void step_controller(input in_item_t it);
		longint             dt, cq, idt, u;
		logic signed [31:0] e, ca, cb, cc;
		if (it.operation == OP_CLEAR) begin
			last_u = '0;
			err1 = '0;
			err2 = '0;
			return;
		end
		dt = longint'(it.interval);
		if (dt == 0) begin
			drive_expect_q.push_back(clamp_drive(last_u, 1'b1));
			return;
		end
		e   = clip_word(longint'(it.target) - longint'(it.measured));
		cq  = (longint'(kd) * 65536) / dt;
		idt = (longint'(ki) * dt) >>> 16;
		ca  = clip_word(longint'(kp) + cq);
		cb  = clip_word(-longint'(kp) + idt - 2 * cq);
		cc  = clip_word(cq);
		u   = longint'(last_u)
		    + ((longint'(ca) * longint'(e)) >>> 16)
		    + ((longint'(cb) * longint'(err1)) >>> 16)
		    + ((longint'(cc) * longint'(err2)) >>> 16);
		last_u = clip_word(u);
		err2 = err1;
		err1 = e;
		drive_expect_q.push_back(clamp_drive(last_u, 1'b0));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			kp = '0;
			ki = '0;
			kd = '0;
			drive_lo = FLOOR_RST;
			drive_hi = CEIL_RST;
			last_u = '0;
			err1 = '0;
			err2 = '0;
			drive_expect_q.delete();
			mismatches = 0;
			outstanding = 0;
			compared = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_P_GAIN:        kp = cfg_data;
					REG_I_GAIN:        ki = cfg_data;
					REG_D_GAIN:        kd = cfg_data;
					REG_DRIVE_FLOOR:   drive_lo = cfg_data;
					REG_DRIVE_CEILING: drive_hi = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (drive_expect_q.size() == 0) begin
					$display("%0t: unexpected item expected none actual %h", $time, out_item);
					mismatches++;
				end else begin
					want = drive_expect_q.pop_front();
					compared++;
					if (out_item.drive !== want.drive) begin
						$display("%0t: drive expected %h actual %h",
							$time, want.drive, out_item.drive);
					end
					if (out_item.limited !== want.limited) begin
						$display("%0t: limited expected %b actual %b",
							$time, want.limited, out_item.limited);
					end
					if (out_item.bad_interval !== want.bad_interval) begin
						$display("%0t: bad_interval expected %b actual %b",
							$time, want.bad_interval, out_item.bad_interval);
					end
					if (out_item !== want) begin
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				step_controller(in_item);
			end
			outstanding = drive_expect_q.size();
		end
	end

endmodule

// ----- dv/incremental_pid_step_top_tb.sv -----
// Testbench top for the incremental PID step: clock, reset, stimulus, receiver stalls, verdict.
`timescale 1ns / 1ps

module incremental_pid_step_top_tb;
	import ipid_pkg::*;

	localparam int Q_ONE = 65536;
	localparam int HOLD_CYCLES = 400;
	localparam logic signed [31:0] S_MAX = 32'sh7FFFFFFF;
	localparam logic signed [31:0] S_MIN = 32'sh80000000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_item;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_item;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	int mismatches, outstanding, compared;
	int n_items, n_clear, n_zero_dt, n_settings, burst_left;
	bit squeeze_req, squeeze_done;

	incremental_pid_step_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	pid_step_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .outstanding(outstanding), .compared(compared)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic in_item_t pack_item(input logic op, input logic signed [31:0] tg,
			input logic signed [31:0] ms, input logic [31:0] dt);
		in_item_t it;
		it.operation = op;
		it.target = tg;
		it.measured = ms;
		it.interval = dt;
		return it;
	endfunction

	function automatic logic signed [31:0] rand_gain();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return '0;
			default: return $urandom_range(0, 8 * Q_ONE) - 4 * Q_ONE;
		endcase
	endfunction

	function automatic logic signed [31:0] rand_level();
		case ($urandom_range(0, 7))
			0: return $urandom;
			1: return S_MAX;
			2: return S_MIN;
			default: return $urandom_range(0, 1000 * Q_ONE) - 500 * Q_ONE;
		endcase
	endfunction

	function automatic in_item_t rand_item();
		logic [31:0] dt;
		case ($urandom_range(0, 19))
			0: dt = '0;
			1: dt = 32'd1;
			2: dt = 32'hFFFFFFFF;
			3, 4: dt = $urandom;
			default: dt = $urandom_range(32'h400, 32'h40000);
		endcase
		return pack_item(($urandom_range(0, 24) == 0) ? OP_CLEAR : OP_COMPUTE,
			rand_level(), rand_level(), dt);
	endfunction

	// sender: bursts of items with random gaps between bursts
	task automatic offer(input in_item_t it);
		int  gap;
		bit  stalled;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		in_valid <= 1'b1;
		in_item <= it;
		forever begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
			if (!stalled) break;
		end
		burst_left--;
		n_items++;
		if (it.operation == OP_CLEAR) begin
			n_clear++;
		end else if (it.interval == '0) begin
			n_zero_dt++;
		end
	endtask

	// drain every pending result, then cover the compute latency for trailing clears
	task automatic quiesce();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(negedge clk); while (outstanding != 0);
		repeat (64) @(posedge clk);
	endtask

	task automatic load_settings(input logic signed [31:0] g_p, input logic signed [31:0] g_i,
			input logic signed [31:0] g_d, input logic signed [31:0] lo,
			input logic signed [31:0] hi);
		logic [31:0] vals[5];
		vals[0] = g_p;
		vals[1] = g_i;
		vals[2] = g_d;
		vals[3] = lo;
		vals[4] = hi;
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data <= vals[i];
			@(posedge clk);
		end
		// indexes past the last register are ignored
		cfg_index <= 3'($urandom_range(5, 7));
		cfg_data <= $urandom;
		@(posedge clk);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	task automatic run_random(input int count, input bit squeeze);
		logic signed [31:0] lo, hi;
		case ($urandom_range(0, 5))
			0: begin
				lo = S_MIN;
				hi = S_MAX;
			end
			1: begin
				hi = $urandom_range(0, 200 * Q_ONE) - 200 * Q_ONE;
				lo = hi + $urandom_range(1, 200 * Q_ONE);
			end
			default: begin
				lo = $urandom_range(0, 400 * Q_ONE) - 200 * Q_ONE;
				hi = lo + $urandom_range(0, 400 * Q_ONE);
			end
		endcase
		quiesce();
		load_settings(rand_gain(), rand_gain(), rand_gain(), lo, hi);
		for (int k = 0; k < count; k++) begin
			if (squeeze && k == 40) begin
				squeeze_req = 1'b1;
			end
			offer(rand_item());
		end
	endtask

	// receiver: stall patterns, plus one long hold-off on request
	initial begin
		int  mode, span;
		out_stall = 1'b0;
		forever begin
			if (squeeze_req && !squeeze_done) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				squeeze_done = 1'b1;
			end else begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(8, 80);
				for (int k = 0; k < span; k++) begin
					case (mode)
						0: out_stall <= 1'b0;
						1: out_stall <= 1'($urandom_range(0, 1));
						2: out_stall <= (k < span / 2);
						default: out_stall <= ($urandom_range(0, 7) == 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		n_items = 0;
		n_clear = 0;
		n_zero_dt = 0;
		n_settings = 0;
		burst_left = 0;
		squeeze_req = 1'b0;
		squeeze_done = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: zero gains, limits 60.0 and 380.0
		offer(pack_item(OP_COMPUTE, Q_ONE, 0, Q_ONE));
		offer(pack_item(OP_COMPUTE, 0, 0, '0));
		offer(pack_item(OP_CLEAR, 0, 0, Q_ONE));
		quiesce();

		load_settings(Q_ONE, Q_ONE / 2, Q_ONE / 4, -1000 * Q_ONE, 1000 * Q_ONE);
		offer(pack_item(OP_COMPUTE, 10 * Q_ONE, 2 * Q_ONE, Q_ONE));
		offer(pack_item(OP_COMPUTE, 10 * Q_ONE, 5 * Q_ONE, Q_ONE / 2));
		offer(pack_item(OP_COMPUTE, 7 * Q_ONE, 0, '0));
		offer(pack_item(OP_COMPUTE, S_MAX, S_MIN, Q_ONE));
		offer(pack_item(OP_COMPUTE, S_MIN, S_MAX, Q_ONE));
		offer(pack_item(OP_COMPUTE, 3 * Q_ONE, -3 * Q_ONE, 32'd1));
		offer(pack_item(OP_COMPUTE, -2 * Q_ONE, Q_ONE, 32'hFFFFFFFF));
		offer(pack_item(OP_CLEAR, S_MAX, S_MIN, '0));
		offer(pack_item(OP_COMPUTE, 3 * Q_ONE, 0, Q_ONE));
		offer(pack_item(OP_COMPUTE, 0, 0, Q_ONE / 4));
		quiesce();

		load_settings(S_MAX, S_MIN, S_MAX, S_MIN, S_MAX);
		offer(pack_item(OP_COMPUTE, S_MAX, S_MIN, Q_ONE));
		offer(pack_item(OP_COMPUTE, S_MIN, S_MAX, 32'd1));
		offer(pack_item(OP_COMPUTE, S_MAX, 0, 32'hFFFFFFFF));
		offer(pack_item(OP_COMPUTE, 0, 0, '0));
		offer(pack_item(OP_COMPUTE, S_MIN, S_MAX, Q_ONE));
		quiesce();

		load_settings(S_MIN, S_MAX, S_MIN, S_MAX, S_MIN);
		offer(pack_item(OP_COMPUTE, 5 * Q_ONE, 0, Q_ONE));
		offer(pack_item(OP_COMPUTE, -5 * Q_ONE, 0, 32'd1));
		quiesce();

		// floor above ceiling
		load_settings(2 * Q_ONE, 0, 0, 100 * Q_ONE, -100 * Q_ONE);
		offer(pack_item(OP_COMPUTE, 50 * Q_ONE, 0, Q_ONE));
		offer(pack_item(OP_COMPUTE, -400 * Q_ONE, 0, Q_ONE));

		for (int p = 0; p < 8; p++) begin
			run_random(125, p == 3);
		end
		quiesce();

		$display("Sent %0d items over %0d register settings: %0d clears, %0d zero intervals.",
			n_items, n_settings, n_clear, n_zero_dt);
		$display("Compared %0d results; receiver held off once for %0d cycles.",
			compared, HOLD_CYCLES);
		if (outstanding != 0) begin
			$display("%0t: %0d expected results never arrived", $time, outstanding);
		end
		if (mismatches == 0 && outstanding == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
